FILE: design/lpcd_pkg.sv
// Shared types and constants for the LRU page cache directory.
package lpcd_pkg;

    localparam int LIMIT_W = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd200;
    localparam int DS_W = 16;
    localparam int PG_W = 32;
    localparam int KEY_W = DS_W + PG_W;

    typedef enum logic
    {
        OP_ACCESS = 1'b0,
        OP_MARK   = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t              operation;
        logic [DS_W-1:0]  dataset_id;
        logic [PG_W-1:0]  page_id;
    } req_t;

    typedef struct packed
    {
        logic             hit;
        logic             load_needed;
        logic             evicted;
        logic             writeback_needed;
        logic [DS_W-1:0]  evicted_dataset;
        logic [PG_W-1:0]  evicted_page;
    } rsp_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed
    {
        logic load_req;
        logic search_en;
        logic update_en;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic search_done;
        logic update_done;
        logic out_busy;
    } ctrl_status_t;

endpackage

FILE: design/lpcd_controller.sv
// Sequencer for the directory: accept, search, rank update, commit and emit.
module lpcd_controller import lpcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search_en = 1'b1;
                if (status.search_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update_en = 1'b1;
                if (status.update_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // hold the finished word until the output register is free
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/lpcd_datapath.sv
// Directory storage, scan counters, key compare, rank update and result register.
module lpcd_datapath import lpcd_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  req_t               req,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output rsp_t               rsp,
    input  ctrl_cmd_t          cmd,
    output ctrl_status_t       status
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // storage: keys, modified marks, recency rank of each slot (0 = most recent)
    logic [KEY_W-1:0]  key_mem  [CAPACITY];
    logic              mod_mem  [CAPACITY];
    logic [SLOT_W-1:0] rank_mem [CAPACITY];

    logic [KEY_W-1:0]  key_q;
    logic              mod_q;
    logic [SLOT_W-1:0] rank_q;

    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [SLOT_W-1:0]  mru_reg;
    req_t               req_reg;

    logic [CNT_W-1:0]   srch_idx_reg;
    logic [CNT_W-1:0]   upd_idx_reg;
    logic               cmp_vld_reg;
    logic               upd_vld_reg;
    logic [SLOT_W-1:0]  upd_slot_reg;
    logic [SLOT_W-1:0]  cmp_slot_reg;

    logic               hit_reg;
    logic [SLOT_W-1:0]  hit_slot_reg;
    logic [SLOT_W-1:0]  hit_rank_reg;
    logic [SLOT_W-1:0]  vic_slot_reg;
    logic [KEY_W-1:0]   vic_key_reg;
    logic               vic_mod_reg;

    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               is_mark;
    logic [KEY_W-1:0]   req_key;
    logic               key_match;
    logic               srch_issue;
    logic               upd_issue;
    logic [SLOT_W-1:0]  srch_addr;
    logic [SLOT_W-1:0]  upd_addr;
    logic [SLOT_W-1:0]  rank_raddr;
    logic [CMP_W-1:0]   eff_limit;
    logic [CMP_W-1:0]   lim_ext;
    logic               alloc;
    logic               evict;
    logic [SLOT_W-1:0]  target;
    logic [CNT_W-1:0]   ref_rank;
    logic [SLOT_W-1:0]  rank_upd;

    logic               key_we;
    logic               mod_we;
    logic [SLOT_W-1:0]  mod_wa;
    logic               mod_wd;
    logic               rank_we;
    logic [SLOT_W-1:0]  rank_wa;
    logic [SLOT_W-1:0]  rank_wd;
    rsp_t               result;

    assign is_mark   = (req_reg.operation == OP_MARK);
    assign req_key   = {req_reg.dataset_id, req_reg.page_id};
    assign key_match = cmp_vld_reg && (key_q == req_key);

    assign srch_addr  = srch_idx_reg[SLOT_W-1:0];
    assign upd_addr   = upd_idx_reg[SLOT_W-1:0];
    assign rank_raddr = cmd.search_en ? srch_addr : upd_addr;

    // stop issuing reads once a match is seen
    assign srch_issue = cmd.search_en && !is_mark && !hit_reg && !key_match
                        && (srch_idx_reg < used_reg);
    assign upd_issue  = cmd.update_en && !is_mark && (upd_idx_reg < used_reg);

    // effective limit: zero acts as one, saturate at capacity
    always_comb
    begin
        lim_ext = CMP_W'(limit_reg);
        if (lim_ext == '0)
        begin
            eff_limit = CMP_W'(1);
        end
        else if (lim_ext > CMP_W'(CAPACITY))
        begin
            eff_limit = CMP_W'(CAPACITY);
        end
        else
        begin
            eff_limit = lim_ext;
        end
    end

    assign alloc  = !hit_reg && (CMP_W'(used_reg) < eff_limit);
    assign evict  = !hit_reg && !alloc;
    assign target = hit_reg ? hit_slot_reg : (alloc ? used_reg[SLOT_W-1:0] : vic_slot_reg);

    // ranks below the reference rank age by one; the target is rewritten at commit
    assign ref_rank = hit_reg ? CNT_W'(hit_rank_reg)
                              : (alloc ? used_reg : CNT_W'(used_reg - 1'b1));
    assign rank_upd = (CNT_W'(rank_q) < ref_rank) ? SLOT_W'(rank_q + 1'b1) : rank_q;

    // a hit keeps its modified mark; a fresh or reused entry starts clean
    always_comb
    begin
        key_we  = cmd.commit && !is_mark;
        mod_we  = cmd.commit && (is_mark ? (used_reg != '0) : !hit_reg);
        mod_wa  = is_mark ? mru_reg : target;
        mod_wd  = is_mark;
        rank_we = upd_vld_reg || (cmd.commit && !is_mark);
        rank_wa = upd_vld_reg ? upd_slot_reg : target;
        rank_wd = upd_vld_reg ? rank_upd : '0;
    end

    always_comb
    begin
        result = '0;
        if (!is_mark)
        begin
            result.hit         = hit_reg;
            result.load_needed = !hit_reg;
            if (evict)
            begin
                result.evicted          = 1'b1;
                result.writeback_needed = vic_mod_reg;
                result.evicted_dataset  = vic_key_reg[KEY_W-1:PG_W];
                result.evicted_page     = vic_key_reg[PG_W-1:0];
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[target] <= req_key;
        end
        key_q <= key_mem[srch_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mod_we)
        begin
            mod_mem[mod_wa] <= mod_wd;
        end
        mod_q <= mod_mem[srch_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_wa] <= rank_wd;
        end
        rank_q <= rank_mem[rank_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            used_reg      <= '0;
            mru_reg       <= '0;
            srch_idx_reg  <= '0;
            upd_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            upd_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            cmp_vld_reg <= srch_issue;
            upd_vld_reg <= upd_issue;
            if (cmd.load_req)
            begin
                srch_idx_reg <= '0;
                upd_idx_reg  <= '0;
                hit_reg      <= 1'b0;
            end
            else
            begin
                if (srch_issue)
                begin
                    srch_idx_reg <= srch_idx_reg + 1'b1;
                end
                if (upd_issue)
                begin
                    upd_idx_reg <= upd_idx_reg + 1'b1;
                end
                if (key_match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.commit && !is_mark)
            begin
                mru_reg <= target;
                if (alloc)
                begin
                    used_reg <= used_reg + 1'b1;
                end
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        cmp_slot_reg <= srch_addr;
        upd_slot_reg <= upd_addr;
        if (key_match && !hit_reg)
        begin
            hit_slot_reg <= cmp_slot_reg;
            hit_rank_reg <= rank_q;
        end
        if (cmp_vld_reg && !hit_reg && (CNT_W'(rank_q) == CNT_W'(used_reg - 1'b1)))
        begin
            vic_slot_reg <= cmp_slot_reg;
            vic_key_reg  <= key_q;
            vic_mod_reg  <= mod_q;
        end
        if (cmd.commit)
        begin
            rsp_reg <= result;
        end
    end

    assign status.search_done = !cmp_vld_reg
                                && (is_mark || hit_reg || (srch_idx_reg >= used_reg));
    assign status.update_done = !upd_vld_reg && (is_mark || (upd_idx_reg >= used_reg));
    assign status.out_busy    = rsp_valid_reg && !rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_used_grow: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg >= $past(used_reg))
        else $error("entry count shrank");

    a_rank_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(upd_vld_reg && cmd.commit))
        else $error("rank write collision between update pass and commit");

    a_hit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (used_reg != '0))
        else $error("hit reported on empty directory");

endmodule

FILE: design/lru_page_cache_directory_core.sv
// Top level of the LRU page cache directory: controller plus datapath.
// Usage:
//   Request channel (req_valid / req_ready / req) carries one word per lookup:
//   operation OP_ACCESS looks up {dataset_id, page_id}, OP_MARK sets the
//   modified flag of the most recent entry (key fields ignored).
//   Response channel (rsp_valid / rsp_ready / rsp) returns one word per request:
//   hit, load_needed, and on eviction the dropped key and its writeback flag.
//   cfg_we / cfg_data write the entry limit at any edge; write only while idle.
// Sequence:
//   One request at a time. With N >= 1 entries in use a miss runs from accept to
//   rsp_valid through a key scan of the N entries (a hit ends it early), a rank
//   aging pass over them and a commit step. A mark or an empty directory skips
//   the scan and the aging pass. req_ready returns the cycle after commit, even
//   while the response word waits; a new word is not taken before commit.
// Reset:
//   The directory starts empty and the limit returns to 200; storage is not
//   cleared, the fill count guards every read.
// Stall:
//   If the receiver holds rsp_ready low, hold the next result in the commit
//   step until the output register drains.
module lru_page_cache_directory_core import lpcd_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // sequencer: walks each request through search, update and commit
    lpcd_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // storage, compare, rank aging and the response register
    lpcd_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
